// ===== design/spp_pkg.sv =====
package spp_pkg;

   localparam int BINS_DEFAULT      = 1024;
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int QUEUE_DEPTH       = 4;

   localparam int PWR_W   = 40;
   localparam int TOT_W   = 41;
   localparam int SUM_W   = 42;
   localparam int POS_W   = 18;
   localparam int RATIO_W = 17;

   typedef struct packed {
      logic [PWR_W-1:0] left_power;
      logic [PWR_W-1:0] right_power;
      logic             last_bin;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]   peak_position;
      logic [SUM_W-1:0]   peak_power;
      logic [RATIO_W-1:0] stereo_ratio;
   } rsp_type;

   // one detected peak: window around it and the integer position in Q format
   typedef struct packed {
      logic [2:0][TOT_W-1:0] pwr;
      logic [2:0][PWR_W-1:0] lft;
      logic [2:0][PWR_W-1:0] rgt;
      logic [POS_W-1:0]      base;
   } peak_type;

endpackage

// ===== design/spectral_peak_picker.sv =====
// Input: one bin per cycle while the peak queue has room (full follows the queue).
// Each peak goes through the back end in turn: setup, FRAC_BITS-1 offset
// division steps, sums, 17 ratio division steps and the output write, all on one
// shared restoring divider.
// Synchronous reset clears the threshold, bin windows, bin index, queue and output.
module spectral_peak_picker #(
   parameter int BINS      = spp_pkg::BINS_DEFAULT,
   parameter int FRAC_BITS = spp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  spp_pkg::req_type          req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output spp_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [spp_pkg::PWR_W-1:0] csr_data
);

   logic              accept, peak_push, q_empty, q_full, q_pop;
   spp_pkg::peak_type peak_data, q_data;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   spp_front #(.BINS(BINS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .peak_push (peak_push),
      .peak_data (peak_data)
   );

   spp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (peak_push),
      .push_data (peak_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   spp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/spp_front.sv =====
module spp_front #(
   parameter int BINS      = spp_pkg::BINS_DEFAULT,
   parameter int FRAC_BITS = spp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  spp_pkg::req_type              req_data,
   input  logic                          csr_valid,
   input  logic [spp_pkg::PWR_W-1:0]     csr_data,
   output logic                          peak_push,
   output spp_pkg::peak_type             peak_data
);

   localparam int IW = $clog2(BINS);

   logic [spp_pkg::PWR_W-1:0]            thresh_ff;
   logic [1:0][spp_pkg::TOT_W-1:0]       pwr_ff, pwr_in;
   logic [1:0][spp_pkg::PWR_W-1:0]       lft_ff, lft_in;
   logic [1:0][spp_pkg::PWR_W-1:0]       rgt_ff, rgt_in;
   logic [IW-1:0]                        idx_ff, idx_in;
   logic [spp_pkg::TOT_W-1:0]            raw_tot, tot;
   logic [spp_pkg::POS_W-1:0]            idx_wide;

   assign raw_tot = {1'b0, req_data.left_power} + {1'b0, req_data.right_power};
   assign tot     = (raw_tot < {1'b0, thresh_ff}) ? '0 : raw_tot;

   assign pwr_in = {tot, pwr_ff[1]};
   assign lft_in = {req_data.left_power, lft_ff[1]};
   assign rgt_in = {req_data.right_power, rgt_ff[1]};
   assign idx_in = (req_data.last_bin || idx_ff == IW'(BINS - 1)) ? '0 : idx_ff + 1'b1;

   assign idx_wide = spp_pkg::POS_W'(idx_ff);

   assign peak_push = accept && idx_ff >= IW'(2) &&
                      pwr_ff[1] > pwr_ff[0] && pwr_ff[1] > tot;

   assign peak_data.pwr  = {tot, pwr_ff[1], pwr_ff[0]};
   assign peak_data.lft  = {req_data.left_power, lft_ff[1], lft_ff[0]};
   assign peak_data.rgt  = {req_data.right_power, rgt_ff[1], rgt_ff[0]};
   assign peak_data.base = spp_pkg::POS_W'((idx_wide - 1'b1) << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
         pwr_ff    <= '0;
         lft_ff    <= '0;
         rgt_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         if (csr_valid) begin
            thresh_ff <= csr_data;
         end
         if (accept) begin
            pwr_ff <= pwr_in;
            lft_ff <= lft_in;
            rgt_ff <= rgt_in;
            idx_ff <= idx_in;
         end
      end
   end

endmodule

// ===== design/spp_queue.sv =====
module spp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spp_pkg::peak_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output spp_pkg::peak_type pop_data
);

   localparam int DEPTH = spp_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);

   spp_pkg::peak_type mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [AW:0]       cnt_ff;

   assign full     = cnt_ff == (AW+1)'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/spp_back.sv =====
module spp_back #(
   parameter int FRAC_BITS = spp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  spp_pkg::peak_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output spp_pkg::rsp_type  rsp_data
);

   localparam int QW = (FRAC_BITS > 1) ? FRAC_BITS - 1 : 1;
   localparam int SW = spp_pkg::SUM_W;
   localparam int TW = spp_pkg::TOT_W;

   typedef enum logic [2:0] {
      S_IDLE, S_SETUP, S_DIVQ, S_SUMS, S_DIVR, S_DONE
   } state_type;

   state_type                     state_ff;
   spp_pkg::peak_type             ent_ff;
   logic [SW:0]                   rem_ff;
   logic [SW-1:0]                 den_ff;
   logic [spp_pkg::RATIO_W-1:0]   quo_ff;
   logic [4:0]                    cnt_ff;
   logic                          neg_ff, zero_ff, out_valid_ff;
   logic [spp_pkg::POS_W-1:0]     pos_ff;
   logic [SW-1:0]                 psum_ff;
   spp_pkg::rsp_type              out_ff;

   logic [SW:0]                   sh, nrem;
   logic                          ge;
   logic [QW-1:0]                 qm;
   logic                          lo;
   logic [TW-1:0]                 ym, y0, y1;
   logic [TW-1:0]                 lsum, rsum;

   assign ym = ent_ff.pwr[0];
   assign y0 = ent_ff.pwr[1];
   assign y1 = ent_ff.pwr[2];

   // shared restoring divider step; first ratio step has no doubling
   assign sh   = (state_ff == S_DIVR && cnt_ff == '0) ? rem_ff : {rem_ff[SW-1:0], 1'b0};
   assign ge   = sh >= {1'b0, den_ff};
   assign nrem = ge ? sh - {1'b0, den_ff} : sh;

   assign qm   = (FRAC_BITS > 1) ? quo_ff[QW-1:0] : '0;
   assign lo   = !(neg_ff && qm != '0);
   assign lsum = lo ? {1'b0, ent_ff.lft[1]} + {1'b0, ent_ff.lft[2]}
                    : {1'b0, ent_ff.lft[0]} + {1'b0, ent_ff.lft[1]};
   assign rsum = lo ? {1'b0, ent_ff.rgt[1]} + {1'b0, ent_ff.rgt[2]}
                    : {1'b0, ent_ff.rgt[0]} + {1'b0, ent_ff.rgt[1]};

   assign q_pop     = state_ff == S_IDLE && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  ent_ff   <= q_data;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               neg_ff <= y1 < ym;
               rem_ff <= (SW+1)'((y1 < ym) ? ym - y1 : y1 - ym);
               den_ff <= SW'(y0 - y1) + SW'(y0 - ym);
               quo_ff <= '0;
               cnt_ff <= '0;
               state_ff <= (FRAC_BITS > 1) ? S_DIVQ : S_SUMS;
            end
            S_DIVQ: begin
               rem_ff <= nrem;
               quo_ff <= {quo_ff[spp_pkg::RATIO_W-2:0], ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'(FRAC_BITS - 2)) begin
                  state_ff <= S_SUMS;
               end
            end
            S_SUMS: begin
               pos_ff  <= neg_ff ? ent_ff.base - spp_pkg::POS_W'(qm)
                                 : ent_ff.base + spp_pkg::POS_W'(qm);
               psum_ff <= lo ? SW'(y0) + SW'(y1) : SW'(ym) + SW'(y0);
               rem_ff  <= (SW+1)'(lsum);
               den_ff  <= SW'(lsum) + SW'(rsum);
               zero_ff <= lsum == '0 && rsum == '0;
               quo_ff  <= '0;
               cnt_ff  <= '0;
               state_ff <= S_DIVR;
            end
            S_DIVR: begin
               rem_ff <= nrem;
               quo_ff <= {quo_ff[spp_pkg::RATIO_W-2:0], ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'(spp_pkg::RATIO_W - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!out_valid_ff) begin
                  out_ff.peak_position <= pos_ff;
                  out_ff.peak_power    <= psum_ff;
                  out_ff.stereo_ratio  <= zero_ff ? '0 : quo_ff;
                  out_valid_ff         <= 1'b1;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/spp_checker.sv =====
module spp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_full,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input spp_pkg::rsp_type          rsp_data
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result after reset");

   // the peak queue starts out with room
   a_reset_room: assert property (@(posedge clock) $past(reset) |-> !req_full)
      else $error("full after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting word changed");

   a_ratio: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.stereo_ratio <= 17'd65536)
      else $error("ratio above one");

   // the peak bin is always one of the two summed bins
   a_power: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.peak_power != '0)
      else $error("zero power peak");

endmodule

bind spectral_peak_picker spp_checker u_spp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NBINS       = spp_pkg::BINS_DEFAULT;
   localparam int  FB          = spp_pkg::FRAC_BITS_DEFAULT;
   localparam int  LATENCY     = FB + 40;
   localparam int  N_RANDOM    = 500;
   localparam longint MAX_CYC  = 1500000;
   localparam logic [39:0] PMAX = 40'hFF_FFFF_FFFF;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_push = 0;
   logic    req_full;
   spp_pkg::req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 0;
   spp_pkg::rsp_type rsp_data;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [spp_pkg::PWR_W-1:0] csr_data = '0;

   spectral_peak_picker i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [39:0] thr;
   logic [40:0] pw [3];
   logic [39:0] lw [3];
   logic [39:0] rw [3];
   int unsigned bidx;

   spp_pkg::rsp_type peak_q[$];
   int      mism = 0;
   int      peaks_seen = 0;
   int      frames = 0;
   longint  cyc = 0;

   // directed rows; fixed expectation only where obvious
   typedef struct {
      logic [39:0] l;
      logic [39:0] r;
      logic        last;
      logic        has_fixed;
      spp_pkg::rsp_type fixed;
   } row_type;

   row_type rows[$];

   function automatic spp_pkg::rsp_type mk(logic [17:0] p, logic [41:0] w, logic [16:0] s);
      spp_pkg::rsp_type t;
      t.peak_position = p; t.peak_power = w; t.stereo_ratio = s;
      return t;
   endfunction

   function automatic void add_row(logic [39:0] l, logic [39:0] r, logic last,
                                   logic has_fixed, spp_pkg::rsp_type fx);
      row_type nr;
      nr.l = l; nr.r = r; nr.last = last; nr.has_fixed = has_fixed; nr.fixed = fx;
      rows = {rows, nr};
   endfunction

   function automatic void peak_reset();
      thr = '0; bidx = 0;
      for (int k = 0; k < 3; k++) begin
         pw[k] = '0; lw[k] = '0; rw[k] = '0;
      end
   endfunction

   // returns 1 and the peak when this bin completes one
   function automatic bit peak_predict(spp_pkg::req_type it, output spp_pkg::rsp_type res);
      logic [40:0] tot, ym, y0, y1, mag;
      logic [42:0] den;
      logic [63:0] qm, lsum, rsum, ratio;
      logic [17:0] base;
      bit          neg, found;
      int          lo;
      found = 0;
      res = '0;
      tot = {1'b0, it.left_power} + {1'b0, it.right_power};
      if (tot < {1'b0, thr}) tot = '0;
      pw[0] = pw[1]; pw[1] = pw[2]; pw[2] = tot;
      lw[0] = lw[1]; lw[1] = lw[2]; lw[2] = it.left_power;
      rw[0] = rw[1]; rw[1] = rw[2]; rw[2] = it.right_power;
      if (bidx >= 2 && pw[1] > pw[0] && pw[1] > pw[2]) begin
         ym = pw[0]; y0 = pw[1]; y1 = pw[2];
         den = {2'b0, y0 - y1} + {2'b0, y0 - ym};
         neg = y1 < ym;
         mag = neg ? ym - y1 : y1 - ym;
         qm = 0;
         if (den != 0) qm = ({23'b0, mag} << (FB - 1)) / {21'b0, den};
         base = 18'((bidx - 1) << FB);
         res.peak_position = neg ? base - 18'(qm) : base + 18'(qm);
         lo = (neg && qm != 0) ? 0 : 1;
         lsum = 64'(lw[lo]) + 64'(lw[lo+1]);
         rsum = 64'(rw[lo]) + 64'(rw[lo+1]);
         ratio = 0;
         if (lsum + rsum != 0) ratio = (lsum << 16) / (lsum + rsum);
         res.peak_power = 42'(pw[lo]) + 42'(pw[lo+1]);
         res.stereo_ratio = ratio[16:0];
         found = 1;
      end
      if (it.last_bin || bidx >= NBINS - 1) begin
         bidx = 0; frames++;
      end else bidx++;
      return found;
   endfunction

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > MAX_CYC) begin
         $display("timeout after %0d cycles", cyc);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random pop gaps
   int pop_gap = 0;
   always @(posedge clock) begin
      spp_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (peak_q.size() == 0) begin
               mism++;
               if (mism <= 10) $display("unexpected peak %p", rsp_data);
            end else begin
               e = peak_q.pop_front();
               peaks_seen++;
               if (e !== rsp_data) begin
                  mism++;
                  if (mism <= 10)
                     $display("peak mismatch: pos exp %0d got %0d, ", e.peak_position,
                        rsp_data.peak_position, "pwr exp %0d got %0d, ", e.peak_power,
                        rsp_data.peak_power, "ratio exp %0d got %0d", e.stereo_ratio,
                        rsp_data.stereo_ratio);
               end
            end
         end
         if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            rsp_pop <= 0;
         end else if ($urandom_range(0, 99) < 15) begin
            pop_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 3);
            rsp_pop <= 0;
         end else rsp_pop <= 1;
      end
   end

   // push stays high between back-to-back words; drain drops it
   task automatic push_bin(spp_pkg::req_type it, bit has_fixed, spp_pkg::rsp_type fx);
      spp_pkg::rsp_type res;
      int gap;
      if ($urandom_range(0, 99) < 20) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_data <= it;
      req_push <= 1;
      do @(posedge clock); while (req_full);
      if (peak_predict(it, res)) begin
         if (has_fixed && res !== fx) begin
            mism++;
            if (mism <= 10) $display("predictor disagrees with table: %p vs %p", res, fx);
         end
         peak_q = {peak_q, res};
      end
   endtask

   task automatic drain();
      req_push <= 0;
      while (peak_q.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_thr(logic [39:0] v);
      csr_data <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      thr = v;
   endtask

   function automatic logic [39:0] rnd40();
      logic [39:0] v;
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = PMAX;
         2: v = 40'($urandom_range(0, 255));
         3: v = 40'({$urandom, $urandom} >> $urandom_range(0, 39));
         default: v = 40'({$urandom, $urandom});
      endcase
      return v;
   endfunction

   initial begin
      spp_pkg::req_type it;
      int      flen, k, nitems, spike;
      logic [39:0] thv[4];
      peak_reset();
      // flat then centered peak at bin 1, frame of 3
      add_row('0, '0, 1'b0, 1'b0, '0);
      add_row(40'd100, 40'd100, 1'b0, 1'b0, '0);
      add_row('0, '0, 1'b1, 1'b1, mk(18'(1 << FB), 42'd200, 17'd32768));
      // extremes: all-left peak at max power
      add_row('0, '0, 1'b0, 1'b0, '0);
      add_row(PMAX, '0, 1'b0, 1'b0, '0);
      add_row('0, '0, 1'b0, 1'b1, mk(18'(1 << FB), 42'(PMAX), 17'd65536));
      add_row('0, '0, 1'b1, 1'b0, '0);
      // max-sum peak with skewed neighbors, then an all-right peak
      add_row(40'd10, '0, 1'b0, 1'b0, '0);
      add_row(PMAX, PMAX, 1'b0, 1'b0, '0);
      add_row('0, 40'd5, 1'b0, 1'b0, '0);
      add_row('0, PMAX, 1'b0, 1'b0, '0);
      add_row('0, '0, 1'b1, 1'b0, '0);
      // frame restart: two bins only, then plateau (no strict peak)
      add_row(40'd1, '0, 1'b0, 1'b0, '0);
      add_row(40'd9, '0, 1'b1, 1'b0, '0);
      add_row(40'd5, 40'd5, 1'b0, 1'b0, '0);
      add_row(40'd7, 40'd7, 1'b0, 1'b0, '0);
      add_row(40'd7, 40'd7, 1'b0, 1'b0, '0);
      add_row(40'd1, 40'd1, 1'b1, 1'b0, '0);
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         it.left_power = rows[i].l; it.right_power = rows[i].r; it.last_bin = rows[i].last;
         push_bin(it, rows[i].has_fixed, rows[i].fixed);
      end
      // overlong frame without last flag
      for (k = 0; k < NBINS + 5; k++) begin
         it.left_power = 40'(k % 7 * 3); it.right_power = 40'(k % 5); it.last_bin = 0;
         push_bin(it, 0, '0);
      end
      it = '0; it.last_bin = 1; push_bin(it, 0, '0);
      drain();
      thv[0] = PMAX; thv[1] = 40'd200; thv[2] = 40'h80_0000_0000; thv[3] = '0;
      nitems = 0;
      for (int ph = 0; ph < 4; ph++) begin
         write_thr(thv[ph]);
         while (nitems < (ph + 1) * N_RANDOM / 4) begin
            flen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            for (k = 0; k < flen; k++) begin
               spike = $urandom_range(0, 2);
               it.left_power = rnd40();
               it.right_power = rnd40();
               if (spike == 0 && ph != 0) begin
                  it.left_power = it.left_power >> 8; it.right_power = it.right_power >> 8;
               end
               it.last_bin = (k == flen - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
               push_bin(it, 0, '0);
               nitems++;
            end
         end
         drain();
      end
      $display("covered %0d frames and %0d peaks over four threshold settings", frames, peaks_seen);
      if (mism == 0) $display("end of test: clean");
      else begin
         $display("%0d mismatches", mism);
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
